// ----- hw/rtl/oro_pkg.sv -----
// Shared constants for the oriented rectangle overlap pipeline.
`timescale 1ns / 1ps

package oro_pkg;

    // Number of separating axes tested (the up and right edge vectors of both rectangles)
    localparam int NUM_AXES    = 4;
    // Vectors per transaction: base, up and right of each rectangle
    localparam int NUM_VECS    = 6;
    // Register stages from input to output
    localparam int PIPE_STAGES = 5;

    typedef logic [2:0] vec_idx_t;

    // Vector slots
    localparam vec_idx_t VEC_A_BASE  = 3'd0;
    localparam vec_idx_t VEC_A_UP    = 3'd1;
    localparam vec_idx_t VEC_A_RIGHT = 3'd2;
    localparam vec_idx_t VEC_B_BASE  = 3'd3;
    localparam vec_idx_t VEC_B_UP    = 3'd4;
    localparam vec_idx_t VEC_B_RIGHT = 3'd5;

    // Vector slot that serves as each axis
    localparam vec_idx_t AXIS_VEC [NUM_AXES] =
        '{VEC_A_UP, VEC_A_RIGHT, VEC_B_UP, VEC_B_RIGHT};

endpackage

// ----- hw/rtl/oriented_rectangle_overlap.sv -----
// Pipelined separating axis overlap test for two oriented rectangles.
`timescale 1ns / 1ps
//
// Usage:
//   Input channel (in_valid/in_ready) carries one rectangle pair per
//   transaction: base corner, up edge and right edge of rectangles a and b.
//   Output channel (out_valid/out_ready) returns one overlap bit per pair,
//   in order. overlap is 0 when any up or right edge direction of a or b separates
//   the projections; touching intervals count as separated.
//   Throughput: one pair per cycle while out_ready stays high. The five
//   register stages are the products, the dot-product sums, the min/max
//   edge offsets, the interval ends and the final compare.
//   Reset (rst_n low, asynchronous) empties the pipeline; in-flight pairs
//   are dropped and out_valid goes low.
//   Stall: while out_ready is low a full stage holds only if all later stages
//   are full; others advance, and in_ready drops only once all are full.
//   Nothing is lost or repeated across a stall.
module oriented_rectangle_overlap
    import oro_pkg::*;
#(
    parameter int COORD_BITS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COORD_BITS-1:0] a_base_x,
    input  logic signed [COORD_BITS-1:0] a_base_y,
    input  logic signed [COORD_BITS-1:0] a_up_dx,
    input  logic signed [COORD_BITS-1:0] a_up_dy,
    input  logic signed [COORD_BITS-1:0] a_right_dx,
    input  logic signed [COORD_BITS-1:0] a_right_dy,
    input  logic signed [COORD_BITS-1:0] b_base_x,
    input  logic signed [COORD_BITS-1:0] b_base_y,
    input  logic signed [COORD_BITS-1:0] b_up_dx,
    input  logic signed [COORD_BITS-1:0] b_up_dy,
    input  logic signed [COORD_BITS-1:0] b_right_dx,
    input  logic signed [COORD_BITS-1:0] b_right_dy,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         overlap
);

    localparam int PW = 2 * COORD_BITS;  // product
    localparam int DW = PW + 1;          // dot product
    localparam int OW = PW + 2;          // edge offset sum
    localparam int JW = PW + 3;          // interval end

    // ------------------------------------------------------------------
    // Stage valid chain and advance logic
    // ------------------------------------------------------------------
    logic [PIPE_STAGES-1:0] vld_reg;
    logic [PIPE_STAGES-1:0] vld_next;
    logic [PIPE_STAGES-1:0] adv;

    always_comb
    begin
        adv[PIPE_STAGES-1] = !vld_reg[PIPE_STAGES-1] || out_ready;
        for (int k = PIPE_STAGES - 2; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
        vld_next[0] = in_valid;
        for (int k = 1; k < PIPE_STAGES; k++)
        begin
            vld_next[k] = vld_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < PIPE_STAGES; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= vld_next[k];
                end
            end
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[PIPE_STAGES-1];

    // ------------------------------------------------------------------
    // Input vector slots
    // ------------------------------------------------------------------
    logic signed [COORD_BITS-1:0] vec_x [NUM_VECS];
    logic signed [COORD_BITS-1:0] vec_y [NUM_VECS];

    always_comb
    begin
        vec_x[VEC_A_BASE]  = a_base_x;
        vec_y[VEC_A_BASE]  = a_base_y;
        vec_x[VEC_A_UP]    = a_up_dx;
        vec_y[VEC_A_UP]    = a_up_dy;
        vec_x[VEC_A_RIGHT] = a_right_dx;
        vec_y[VEC_A_RIGHT] = a_right_dy;
        vec_x[VEC_B_BASE]  = b_base_x;
        vec_y[VEC_B_BASE]  = b_base_y;
        vec_x[VEC_B_UP]    = b_up_dx;
        vec_y[VEC_B_UP]    = b_up_dy;
        vec_x[VEC_B_RIGHT] = b_right_dx;
        vec_y[VEC_B_RIGHT] = b_right_dy;
    end

    // ------------------------------------------------------------------
    // Stage 1: per-component products, axis times every vector
    // ------------------------------------------------------------------
    logic signed [PW-1:0] prod_x_reg  [NUM_AXES][NUM_VECS];
    logic signed [PW-1:0] prod_y_reg  [NUM_AXES][NUM_VECS];
    logic signed [PW-1:0] prod_x_next [NUM_AXES][NUM_VECS];
    logic signed [PW-1:0] prod_y_next [NUM_AXES][NUM_VECS];

    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            for (int j = 0; j < NUM_VECS; j++)
            begin
                prod_x_next[i][j] = PW'(vec_x[AXIS_VEC[i]]) * PW'(vec_x[j]);
                prod_y_next[i][j] = PW'(vec_y[AXIS_VEC[i]]) * PW'(vec_y[j]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: dot products
    // ------------------------------------------------------------------
    logic signed [DW-1:0] dot_reg  [NUM_AXES][NUM_VECS];
    logic signed [DW-1:0] dot_next [NUM_AXES][NUM_VECS];

    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            for (int j = 0; j < NUM_VECS; j++)
            begin
                dot_next[i][j] = DW'(prod_x_reg[i][j]) + DW'(prod_y_reg[i][j]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            dot_reg <= dot_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: corner offsets. Over {0, u, r, u+r} the minimum is
    // min(0,u)+min(0,r) and the maximum is max(0,u)+max(0,r).
    // ------------------------------------------------------------------
    logic signed [OW-1:0] a_lo_reg  [NUM_AXES];
    logic signed [OW-1:0] a_hi_reg  [NUM_AXES];
    logic signed [OW-1:0] b_lo_reg  [NUM_AXES];
    logic signed [OW-1:0] b_hi_reg  [NUM_AXES];
    logic signed [DW-1:0] a_org_reg [NUM_AXES];
    logic signed [DW-1:0] b_org_reg [NUM_AXES];
    logic signed [OW-1:0] a_lo_next [NUM_AXES];
    logic signed [OW-1:0] a_hi_next [NUM_AXES];
    logic signed [OW-1:0] b_lo_next [NUM_AXES];
    logic signed [OW-1:0] b_hi_next [NUM_AXES];

    function automatic logic signed [DW-1:0] neg_part(input logic signed [DW-1:0] v);
        return v[DW-1] ? v : '0;
    endfunction

    function automatic logic signed [DW-1:0] pos_part(input logic signed [DW-1:0] v);
        return v[DW-1] ? '0 : v;
    endfunction

    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            a_lo_next[i] = OW'(neg_part(dot_reg[i][VEC_A_UP]))
                         + OW'(neg_part(dot_reg[i][VEC_A_RIGHT]));
            a_hi_next[i] = OW'(pos_part(dot_reg[i][VEC_A_UP]))
                         + OW'(pos_part(dot_reg[i][VEC_A_RIGHT]));
            b_lo_next[i] = OW'(neg_part(dot_reg[i][VEC_B_UP]))
                         + OW'(neg_part(dot_reg[i][VEC_B_RIGHT]));
            b_hi_next[i] = OW'(pos_part(dot_reg[i][VEC_B_UP]))
                         + OW'(pos_part(dot_reg[i][VEC_B_RIGHT]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            a_lo_reg <= a_lo_next;
            a_hi_reg <= a_hi_next;
            b_lo_reg <= b_lo_next;
            b_hi_reg <= b_hi_next;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                a_org_reg[i] <= dot_reg[i][VEC_A_BASE];
                b_org_reg[i] <= dot_reg[i][VEC_B_BASE];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: projection interval ends
    // ------------------------------------------------------------------
    logic signed [JW-1:0] a_min_reg  [NUM_AXES];
    logic signed [JW-1:0] a_max_reg  [NUM_AXES];
    logic signed [JW-1:0] b_min_reg  [NUM_AXES];
    logic signed [JW-1:0] b_max_reg  [NUM_AXES];
    logic signed [JW-1:0] a_min_next [NUM_AXES];
    logic signed [JW-1:0] a_max_next [NUM_AXES];
    logic signed [JW-1:0] b_min_next [NUM_AXES];
    logic signed [JW-1:0] b_max_next [NUM_AXES];

    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            a_min_next[i] = JW'(a_org_reg[i]) + JW'(a_lo_reg[i]);
            a_max_next[i] = JW'(a_org_reg[i]) + JW'(a_hi_reg[i]);
            b_min_next[i] = JW'(b_org_reg[i]) + JW'(b_lo_reg[i]);
            b_max_next[i] = JW'(b_org_reg[i]) + JW'(b_hi_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            a_min_reg <= a_min_next;
            a_max_reg <= a_max_next;
            b_min_reg <= b_min_next;
            b_max_reg <= b_max_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: interval compare; touching intervals separate
    // ------------------------------------------------------------------
    logic overlap_reg;
    logic overlap_next;

    always_comb
    begin
        overlap_next = 1'b1;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            if (!(b_min_reg[i] < a_max_reg[i]) || !(a_min_reg[i] < b_max_reg[i]))
            begin
                overlap_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            overlap_reg <= overlap_next;
        end
    end

    assign overlap = overlap_reg;

endmodule

// ----- hw/rtl/oro_checker.sv -----
// Port-level checker for the oriented rectangle overlap pipeline, with bind.
`timescale 1ns / 1ps

module oro_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic overlap
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(overlap))
        else $error("stalled result changed or dropped");

    // Input back-pressure only when the output is full and stalled
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid || out_ready) |-> in_ready)
        else $error("in_ready low while output can drain");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("out_valid high after reset");

    // With the receiver always ready, out_valid follows each accepted pair
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && out_ready) ##1 out_ready ##1 out_ready
        ##1 out_ready ##1 out_ready |=> out_valid)
        else $error("result missing five cycles after transaction");

endmodule

bind oriented_rectangle_overlap oro_checker u_oro_checker (.*);
